// ===== src/hri_pkg.sv =====
// ----------------------------------------------------------------------------
// Halton radical inverse: shared package
// Field widths, fixed constants and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package hri_pkg;

    // Widths of the fields on the ports.
    localparam int SEQ_W  = 32;   // seq_index
    localparam int FRAC_W = 32;   // fraction
    localparam int CFG_W  = 8;    // radix_base

    // Smallest base that the register accepts.
    localparam int MIN_BASE = 2;

    // Quotient bits produced per cycle by the digit divider.
    localparam int DIV_BITS = 4;

    typedef struct packed {
        logic load;        // take a new index, clear the accumulators
        logic div_step;    // DIV_BITS steps of index / base
        logic acc;         // fold the digit into numerator and denominator
        logic ldiv_step;   // one bit of numerator / denominator
        logic out_load;    // copy the quotient into the output register
    } hri_cmd_t;

    typedef struct packed {
        logic idx_zero;    // index register holds zero
    } hri_sts_t;

endpackage

// ===== src/hri_ctrl.sv =====
// ----------------------------------------------------------------------------
// Halton radical inverse: controller
// Sequences digit extraction, accumulation and the final long division, and
// owns both handshakes.
// ----------------------------------------------------------------------------
module hri_ctrl #(
    parameter int INDEX_BITS = 32,
    parameter int FRAC_BITS  = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output hri_pkg::hri_cmd_t cmd,
    input  hri_pkg::hri_sts_t sts
);
    import hri_pkg::*;

    localparam int GROUPS  = (INDEX_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int CNT_TOP = (GROUPS > FRAC_BITS) ? GROUPS : FRAC_BITS;
    localparam int CNT_W   = $clog2(CNT_TOP);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_LDIV = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mvalid_reg, mvalid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                cnt_next   = '0;
                state_next = sts.idx_zero ? ST_LDIV : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(GROUPS - 1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                // The index register already holds the quotient here.
                cmd.acc    = 1'b1;
                cnt_next   = '0;
                state_next = sts.idx_zero ? ST_LDIV : ST_DIV;
            end
            ST_LDIV: begin
                cmd.ldiv_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_ready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ===== src/hri_dp.sv =====
// ----------------------------------------------------------------------------
// Halton radical inverse: datapath
// Base register, digit divider, numerator and denominator accumulators,
// binary long divider and output register.
// ----------------------------------------------------------------------------
module hri_dp #(
    parameter int INDEX_BITS = 32,
    parameter int FRAC_BITS  = 32,
    parameter int BASE_BITS  = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       base_we,
    input  logic [hri_pkg::CFG_W-1:0]  base_in,
    input  logic [hri_pkg::SEQ_W-1:0]  seq_index,
    output logic [hri_pkg::FRAC_W-1:0] fraction,
    input  hri_pkg::hri_cmd_t          cmd,
    output hri_pkg::hri_sts_t          sts
);
    import hri_pkg::*;

    localparam int GROUPS  = (INDEX_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int IDX_PAD = GROUPS * DIV_BITS;
    localparam int NUM_W   = INDEX_BITS + BASE_BITS;

    logic [BASE_BITS-1:0]  base_reg;
    logic [IDX_PAD-1:0]    idx_reg, idx_next;
    logic [BASE_BITS-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [NUM_W-1:0]      den_reg, den_next;
    logic [FRAC_BITS-1:0]  q_reg, q_next;
    logic [FRAC_W-1:0]     frac_reg;

    logic [SEQ_W+INDEX_BITS-1:0]  seq_ext;
    logic [FRAC_W+FRAC_BITS-1:0]  q_ext;
    logic                         base_ok;

    // Accepted bases are 2 up to 2^BASE_BITS - 1; anything else is dropped.
    assign base_ok = (base_in >= CFG_W'(MIN_BASE)) && ((base_in >> BASE_BITS) == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_BITS'(MIN_BASE);
        end else if (base_we && base_ok) begin
            base_reg <= BASE_BITS'(base_in);
        end
    end

    assign seq_ext = {{INDEX_BITS{1'b0}}, seq_index};
    assign q_ext   = {{FRAC_W{1'b0}}, q_reg};

    // Restoring division, MSB first; quotient bits shift into the index
    // register while the remainder builds up in rem.
    always_comb begin
        logic [BASE_BITS:0]   t;
        logic [NUM_W:0]       nt;
        logic [IDX_PAD-1:0]   x;
        logic [BASE_BITS-1:0] r;
        logic [NUM_W+BASE_BITS-1:0] nprod;
        logic [NUM_W+BASE_BITS-1:0] dprod;

        idx_next = idx_reg;
        rem_next = rem_reg;
        num_next = num_reg;
        den_next = den_reg;
        q_next   = q_reg;
        x        = idx_reg;
        r        = rem_reg;
        t        = '0;
        nt       = '0;
        nprod    = num_reg * base_reg;
        dprod    = den_reg * base_reg;

        if (cmd.load) begin
            idx_next = IDX_PAD'(seq_ext[INDEX_BITS-1:0]);
            rem_next = '0;
            num_next = '0;
            den_next = NUM_W'(1);
            q_next   = '0;
        end else if (cmd.div_step) begin
            for (int i = 0; i < DIV_BITS; i++) begin
                t = {r, x[IDX_PAD-1]};
                x = {x[IDX_PAD-2:0], 1'b0};
                if (t >= {1'b0, base_reg}) begin
                    r    = BASE_BITS'(t - {1'b0, base_reg});
                    x[0] = 1'b1;
                end else begin
                    r = t[BASE_BITS-1:0];
                end
            end
            idx_next = x;
            rem_next = r;
        end else if (cmd.acc) begin
            num_next = NUM_W'(nprod) + NUM_W'(rem_reg);
            den_next = NUM_W'(dprod);
            rem_next = '0;
        end else if (cmd.ldiv_step) begin
            nt = {num_reg, 1'b0};
            if (nt >= {1'b0, den_reg}) begin
                num_next = NUM_W'(nt - {1'b0, den_reg});
                q_next   = {q_reg[FRAC_BITS-2:0], 1'b1};
            end else begin
                num_next = nt[NUM_W-1:0];
                q_next   = {q_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        if (cmd.out_load) begin
            frac_reg <= q_ext[FRAC_W-1:0];
        end
    end

    assign sts.idx_zero = (idx_reg == '0);
    assign fraction     = frac_reg;

endmodule

// ===== src/halton_radical_inverse_top.sv =====
// ----------------------------------------------------------------------------
// Halton radical inverse: top level
// Mirrors the base-b digits of a sequence index about the radix point and
// returns the result as an exact, truncated binary fraction.
// ----------------------------------------------------------------------------
//
//  Channel   Ports            Direction  Content
//  --------  ---------------  ---------  ---------------------------------
//  config    radix_base_we/*  in         base b, 2 .. 2^BASE_BITS-1
//  input     s_axis_*         in         seq_index, one item per index
//  result    m_axis_*         out        fraction, one item per index
//
//  After acceptance an item passes a zero check, then for each of its m
//  base-b digits G = ceil(INDEX_BITS/4) divider steps and one accumulate
//  step, then FRAC_BITS long-division steps: the digit divider yields four
//  quotient bits a cycle and the long divider one fraction bit a cycle.
//  Reset is synchronous and active low; it restores base 2 and clears the
//  result valid flag. A result waiting on m_axis_tready holds only the final
//  hand-over; the next item may already be accepted and worked on.
//
module halton_radical_inverse_top #(
    parameter int INDEX_BITS = 32,
    parameter int FRAC_BITS  = 32,
    parameter int BASE_BITS  = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    // Base register write; values outside the accepted range are ignored.
    input  logic                       radix_base_we,
    input  logic [hri_pkg::CFG_W-1:0]  radix_base,

    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [hri_pkg::SEQ_W-1:0]  s_axis_tdata,   // [31:0] seq_index

    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [hri_pkg::FRAC_W-1:0] m_axis_tdata    // [31:0] fraction
);
    import hri_pkg::*;

    hri_cmd_t cmd;
    hri_sts_t sts;

    // The controller decides, cycle by cycle, which datapath operation runs
    // and owns the valid and ready signals of both streams.
    hri_ctrl #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // The datapath holds the base, the working index, the mirrored numerator
    // with its power-of-base denominator, the quotient and the result
    // register that feeds the output stream.
    hri_dp #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .BASE_BITS  (BASE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .base_we   (radix_base_we),
        .base_in   (radix_base),
        .seq_index (s_axis_tdata),
        .fraction  (m_axis_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
